FILE: hdl/scm_pkg.sv
// Shared types, constants and helpers for the SIEVE cache slot manager.
package scm_pkg;

   localparam int SLOTS      = 64;
   localparam int IDX_W      = $clog2(SLOTS);
   localparam int CNT_W      = $clog2(SLOTS + 1);
   localparam int KEY_W      = 32;
   localparam int VER_W      = 32;
   localparam int SLOT_OUT_W = 6;

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;
   typedef logic [KEY_W-1:0] key_type;
   typedef logic [VER_W-1:0] ver_type;

   localparam idx_type IDX_LAST = IDX_W'(SLOTS - 1);
   localparam cnt_type FULL_CNT = CNT_W'(SLOTS);

   typedef enum logic [1:0] {
      STAT_HIT     = 2'd0,
      STAT_STALE   = 2'd1,
      STAT_MISS    = 2'd2,
      STAT_INVALID = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_SCAN,
      SEQ_HIT_VER,
      SEQ_SWEEP,
      SEQ_EVICT,
      SEQ_INSERT,
      SEQ_WRITE,
      SEQ_DONE
   } seq_state_type;

   // Slot RAM control from the sequencer
   typedef struct packed {
      logic    we;
      idx_type wr_addr;
      key_type wr_key;
      ver_type wr_ver;
      idx_type rd_addr;
   } ram_ctl_type;

   // One finished transaction result
   typedef struct packed {
      status_type                  status;
      logic [SLOT_OUT_W-1:0]       slot;
      logic                        evicted;
      key_type                     evicted_key;
   } result_type;

   // Circular successor of a slot index
   function automatic idx_type next_idx(input idx_type idx);
      return (idx == IDX_LAST) ? '0 : idx + 1'b1;
   endfunction

   // Slot index as reported on the result port, kept to its low 6 bits
   function automatic logic [SLOT_OUT_W-1:0] slot_out(input idx_type idx);
      logic [IDX_W+SLOT_OUT_W-1:0] wide;
      wide = {{SLOT_OUT_W{1'b0}}, idx};
      return wide[SLOT_OUT_W-1:0];
   endfunction

endpackage

FILE: hdl/scm_slot_ram.sv
// Single write port, single registered read port RAM.
module scm_slot_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write, then register the read word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/scm_sequencer.sv
// Lookup, SIEVE sweep and insert sequencer around one shared equality comparator.
module scm_sequencer
   import scm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  key_type     req_key,
   input  ver_type     req_version,
   output ram_ctl_type ram_ctl,
   input  key_type     key_rd,
   input  ver_type     ver_rd,
   input  logic        out_free,
   output logic        res_valid,
   output result_type  res
);

   seq_state_type    state_ff, state_in;
   idx_type          ptr_ff, ptr_in;
   idx_type          step_ff, step_in;
   logic             pass_ff, pass_in;
   idx_type          target_ff, target_in;
   key_type          key_ff, key_in;
   ver_type          ver_ff, ver_in;
   logic [SLOTS-1:0] valid_ff, valid_in;
   logic [SLOTS-1:0] visited_ff, visited_in;
   idx_type          evict_hand_ff, evict_hand_in;
   idx_type          insert_hand_ff, insert_hand_in;
   cnt_type          occ_ff, occ_in;
   logic             evicted_ff, evicted_in;
   key_type          ev_key_ff, ev_key_in;
   status_type       status_ff, status_in;

   logic             cmp_eq;
   key_type          cmp_a;
   key_type          cmp_b;

   // Shared comparator: versions on a hit, keys otherwise
   always_comb begin
      cmp_a  = (state_ff == SEQ_HIT_VER) ? ver_rd : key_rd;
      cmp_b  = (state_ff == SEQ_HIT_VER) ? ver_ff : key_ff;
      cmp_eq = (cmp_a == cmp_b);
   end

   // Hold control state, reset clears tables and hands
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= SEQ_IDLE;
         valid_ff       <= '0;
         visited_ff     <= '0;
         evict_hand_ff  <= '0;
         insert_hand_ff <= '0;
         occ_ff         <= '0;
      end else begin
         state_ff       <= state_in;
         valid_ff       <= valid_in;
         visited_ff     <= visited_in;
         evict_hand_ff  <= evict_hand_in;
         insert_hand_ff <= insert_hand_in;
         occ_ff         <= occ_in;
      end
   end

   // Working registers of the current transaction
   always_ff @(posedge clock) begin
      ptr_ff     <= ptr_in;
      step_ff    <= step_in;
      pass_ff    <= pass_in;
      target_ff  <= target_in;
      key_ff     <= key_in;
      ver_ff     <= ver_in;
      evicted_ff <= evicted_in;
      ev_key_ff  <= ev_key_in;
      status_ff  <= status_in;
   end

   // Next state and outputs
   always_comb begin
      state_in        = state_ff;
      ptr_in          = ptr_ff;
      step_in         = step_ff;
      pass_in         = pass_ff;
      target_in       = target_ff;
      key_in          = key_ff;
      ver_in          = ver_ff;
      valid_in        = valid_ff;
      visited_in      = visited_ff;
      evict_hand_in   = evict_hand_ff;
      insert_hand_in  = insert_hand_ff;
      occ_in          = occ_ff;
      evicted_in      = evicted_ff;
      ev_key_in       = ev_key_ff;
      status_in       = status_ff;
      req_stall       = 1'b1;
      res_valid       = 1'b0;
      ram_ctl.we      = 1'b0;
      ram_ctl.wr_addr = target_ff;
      ram_ctl.wr_key  = key_ff;
      ram_ctl.wr_ver  = ver_ff;
      ram_ctl.rd_addr = ptr_ff;

      unique case (state_ff)
         SEQ_IDLE: begin
            req_stall       = 1'b0;
            ram_ctl.rd_addr = '0;
            if (req_valid) begin
               key_in     = req_key;
               ver_in     = req_version;
               evicted_in = 1'b0;
               ev_key_in  = '0;
               ptr_in     = '0;
               if (req_key == '0) begin
                  status_in = STAT_INVALID;
                  target_in = '0;
                  state_in  = SEQ_DONE;
               end else begin
                  state_in = SEQ_SCAN;
               end
            end
         end

         // Compare one slot per cycle, prefetch the next
         SEQ_SCAN: begin
            if (valid_ff[ptr_ff] && cmp_eq) begin
               target_in       = ptr_ff;
               ram_ctl.rd_addr = ptr_ff;
               state_in        = SEQ_HIT_VER;
            end else if (ptr_ff == IDX_LAST) begin
               if (occ_ff == FULL_CNT) begin
                  ptr_in   = next_idx(evict_hand_ff);
                  step_in  = IDX_W'(1);
                  pass_in  = 1'b0;
                  state_in = SEQ_SWEEP;
               end else begin
                  ptr_in   = insert_hand_ff;
                  state_in = SEQ_INSERT;
               end
            end else begin
               ptr_in          = next_idx(ptr_ff);
               ram_ctl.rd_addr = next_idx(ptr_ff);
            end
         end

         // Check the stored version, refresh it and mark visited
         SEQ_HIT_VER: begin
            status_in             = cmp_eq ? STAT_HIT : STAT_STALE;
            ram_ctl.we            = 1'b1;
            visited_in[target_ff] = 1'b1;
            state_in              = SEQ_DONE;
         end

         // Walk the hand: clear visited, stop at the first unvisited slot
         SEQ_SWEEP: begin
            ram_ctl.rd_addr = ptr_ff;
            if (valid_ff[ptr_ff] && !visited_ff[ptr_ff]) begin
               target_in     = ptr_ff;
               evict_hand_in = ptr_ff;
               state_in      = SEQ_EVICT;
            end else begin
               if (valid_ff[ptr_ff]) begin
                  visited_in[ptr_ff] = 1'b0;
               end
               if (step_ff == IDX_LAST) begin
                  if (!pass_ff) begin
                     ptr_in  = next_idx(evict_hand_ff);
                     step_in = IDX_W'(1);
                     pass_in = 1'b1;
                  end else begin
                     target_in       = evict_hand_ff;
                     ram_ctl.rd_addr = evict_hand_ff;
                     state_in        = SEQ_EVICT;
                  end
               end else begin
                  ptr_in  = next_idx(ptr_ff);
                  step_in = step_ff + 1'b1;
               end
            end
         end

         // Capture the victim key
         SEQ_EVICT: begin
            evicted_in = 1'b1;
            ev_key_in  = key_rd;
            state_in   = SEQ_WRITE;
         end

         // Find a free slot from the insert hand
         SEQ_INSERT: begin
            if (!valid_ff[ptr_ff]) begin
               target_in      = ptr_ff;
               insert_hand_in = ptr_ff;
               state_in       = SEQ_WRITE;
            end else begin
               ptr_in = next_idx(ptr_ff);
            end
         end

         // Place the new key
         SEQ_WRITE: begin
            ram_ctl.we            = 1'b1;
            valid_in[target_ff]   = 1'b1;
            visited_in[target_ff] = 1'b1;
            if (!evicted_ff) begin
               occ_in = occ_ff + 1'b1;
            end
            status_in = STAT_MISS;
            state_in  = SEQ_DONE;
         end

         // Hand the result over once the output register is free
         SEQ_DONE: begin
            if (out_free) begin
               res_valid = 1'b1;
               state_in  = SEQ_IDLE;
            end
         end

         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   always_comb begin
      res.status      = status_ff;
      res.slot        = slot_out(target_ff);
      res.evicted     = evicted_ff;
      res.evicted_key = ev_key_ff;
   end

   // Occupancy never exceeds the table size
   assert property (@(posedge clock) disable iff (reset) occ_ff <= FULL_CNT)
      else $error("occupancy above slot count");

   // A sweep only runs on a full table
   assert property (@(posedge clock) disable iff (reset)
      state_ff == SEQ_SWEEP |-> occ_ff == FULL_CNT)
      else $error("sweep on a table with free slots");

   // An eviction is only reported for a miss
   assert property (@(posedge clock) disable iff (reset)
      res_valid && res.evicted |-> res.status == STAT_MISS)
      else $error("eviction reported without a miss");

   // Valid count follows occupancy
   assert property (@(posedge clock) disable iff (reset)
      state_ff == SEQ_IDLE |-> CNT_W'($countones(valid_ff)) == occ_ff)
      else $error("valid bits disagree with occupancy");

   // A placed or hit slot is left visited
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == SEQ_WRITE || state_ff == SEQ_HIT_VER) |=> visited_ff[$past(target_ff)])
      else $error("target slot not marked visited");

endmodule

FILE: hdl/sieve_cache_slot_manager_unit.sv
// SIEVE cache slot manager: top level with slot RAMs, sequencer and result register.
// Each transaction looks up a nonzero key in a 64-slot table, one slot per cycle through
// the single read port of the key RAM. A hit goes through a version check before its result
// waits in the output register. A miss with free slots scans the whole table, then walks
// the insert hand one slot a cycle to the next free slot. A miss on a full table adds a SIEVE
// sweep of the evict hand, one slot a cycle, at most two passes of SLOTS-1 slots, plus one
// RAM read for the victim key. A zero key is answered as invalid with no state change. The
// block takes one transaction at a time and stalls requests until the sequencer is back in
// idle, in the cycle after the result is handed over; a finished result sits in an output
// register so the next request is taken while it waits on a stalled response channel. No
// clearing pass runs after reset.
module sieve_cache_slot_manager_unit
   import scm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [KEY_W-1:0]      req_key,
   input  logic [VER_W-1:0]      req_version,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_status,
   output logic [SLOT_OUT_W-1:0] rsp_slot,
   output logic                  rsp_evicted,
   output logic [KEY_W-1:0]      rsp_evicted_key
);

   ram_ctl_type ram_ctl;
   key_type     key_rd;
   ver_type     ver_rd;
   logic        out_free;
   logic        res_valid;
   result_type  res;
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_data_ff, rsp_data_in;

   scm_slot_ram #(.WIDTH(KEY_W), .DEPTH(SLOTS)) u_key_ram (
      .clock   (clock),
      .wr_en   (ram_ctl.we),
      .wr_addr (ram_ctl.wr_addr),
      .wr_data (ram_ctl.wr_key),
      .rd_addr (ram_ctl.rd_addr),
      .rd_data (key_rd)
   );

   scm_slot_ram #(.WIDTH(VER_W), .DEPTH(SLOTS)) u_ver_ram (
      .clock   (clock),
      .wr_en   (ram_ctl.we),
      .wr_addr (ram_ctl.wr_addr),
      .wr_data (ram_ctl.wr_ver),
      .rd_addr (ram_ctl.rd_addr),
      .rd_data (ver_rd)
   );

   scm_sequencer u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_key     (req_key),
      .req_version (req_version),
      .ram_ctl     (ram_ctl),
      .key_rd      (key_rd),
      .ver_rd      (ver_rd),
      .out_free    (out_free),
      .res_valid   (res_valid),
      .res         (res)
   );

   // Load a new result when the register empties, drop it once taken
   always_comb begin
      out_free     = !rsp_valid_ff || !rsp_stall;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_data_ff.status;
   assign rsp_slot        = rsp_data_ff.slot;
   assign rsp_evicted     = rsp_data_ff.evicted;
   assign rsp_evicted_key = rsp_data_ff.evicted_key;

endmodule
